// ===== hdl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define SFH_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define SFH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/sfh_pkg.sv =====
// types and mixing functions for the superfast string hash
`default_nettype none

package sfh_pkg;

    typedef struct packed {
        logic [31:0] hash;
        logic [1:0]  count;
        logic [23:0] bytes;
    } t_fin_req;

    function automatic logic [23:0] f_put_byte(
        input logic [23:0] pend,
        input logic [1:0]  pos,
        input logic [7:0]  data
    );
        logic [23:0] res;
        res = pend;
        case (pos)
            2'd0:    res = {pend[23:8], data};
            2'd1:    res = {pend[23:16], data, pend[7:0]};
            2'd2:    res = {data, pend[15:0]};
            default: res = pend;
        endcase
        return res;
    endfunction

    // one full four-byte round
    function automatic logic [31:0] f_mix_round(
        input logic [31:0] h_in,
        input logic [23:0] pend,
        input logic [7:0]  data
    );
        logic [31:0] h;
        logic [31:0] t;
        logic [15:0] hi;
        hi = {data, pend[23:16]};
        h  = h_in + {16'd0, pend[15:0]};
        t  = {5'd0, hi, 11'd0} ^ h;
        h  = {h[15:0], 16'd0} ^ t;
        h  = h + {11'd0, h[31:11]};
        return h;
    endfunction

    function automatic logic [31:0] f_tail_mix(
        input logic [31:0] h_in,
        input logic [1:0]  count,
        input logic [23:0] bytes
    );
        logic [31:0] h;
        h = h_in;
        case (count)
            2'd3: begin
                h = h + {16'd0, bytes[15:0]};
                h = h ^ {h[15:0], 16'd0};
                h = h ^ {{6{bytes[23]}}, bytes[23:16], 18'd0};
                h = h + {11'd0, h[31:11]};
            end
            2'd2: begin
                h = h + {16'd0, bytes[15:0]};
                h = h ^ {h[20:0], 11'd0};
                h = h + {17'd0, h[31:17]};
            end
            2'd1: begin
                h = h + {{24{bytes[7]}}, bytes[7:0]};
                h = h ^ {h[21:0], 10'd0};
                h = h + {1'b0, h[31:1]};
            end
            default: h = h_in;
        endcase
        return h;
    endfunction

    // avalanche, first three steps
    function automatic logic [31:0] f_aval_a(input logic [31:0] h_in);
        logic [31:0] h;
        h = h_in ^ {h_in[28:0], 3'd0};
        h = h + {5'd0, h[31:5]};
        h = h ^ {h[27:0], 4'd0};
        return h;
    endfunction

    // avalanche, last three steps
    function automatic logic [31:0] f_aval_b(input logic [31:0] h_in);
        logic [31:0] h;
        h = h_in + {17'd0, h_in[31:17]};
        h = h ^ {h[6:0], 25'd0};
        h = h + {6'd0, h[31:6]};
        return h;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/sfh_accum.sv =====
// key state register and per-byte round, issues finalize requests
`default_nettype none

module sfh_accum (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [7:0]        i_data_byte,
    input  wire logic              i_start_key,
    input  wire logic [31:0]       i_key_length,
    output logic                   o_req_valid,
    output sfh_pkg::t_fin_req      o_req,
    input  wire logic              i_req_ready
);
    import sfh_pkg::*;

    logic [31:0] r_hash,   n_hash;
    logic [23:0] r_pend,   n_pend;
    logic [1:0]  r_gpos,   n_gpos;
    logic [31:0] r_remain, n_remain;
    logic        r_open,   n_open;
    logic        r_req_valid, n_req_valid;
    t_fin_req    r_req,    n_req;

    logic        w_accept;
    logic        w_live;
    logic        w_zero;
    logic [31:0] w_base_h;
    logic [23:0] w_base_p;
    logic [1:0]  w_base_g;
    logic [31:0] w_base_rem;
    logic [31:0] w_step_h;
    logic [23:0] w_step_p;
    logic [1:0]  w_step_g;
    logic [31:0] w_rem1;

    assign o_ready     = !r_req_valid || i_req_ready;
    assign o_req_valid = r_req_valid;
    assign o_req       = r_req;

    assign w_accept   = i_valid && o_ready;
    assign w_live     = i_start_key || r_open;
    assign w_zero     = i_start_key && (i_key_length == 32'd0);
    assign w_base_h   = i_start_key ? i_key_length : r_hash;
    assign w_base_p   = i_start_key ? 24'd0 : r_pend;
    assign w_base_g   = i_start_key ? 2'd0 : r_gpos;
    assign w_base_rem = i_start_key ? i_key_length : r_remain;
    assign w_rem1     = w_base_rem - 32'd1;

    always_comb begin
        if (w_base_g != 2'd3) begin
            w_step_h = w_base_h;
            w_step_p = f_put_byte(w_base_p, w_base_g, i_data_byte);
            w_step_g = w_base_g + 2'd1;
        end else begin
            w_step_h = f_mix_round(w_base_h, w_base_p, i_data_byte);
            w_step_p = 24'd0;
            w_step_g = 2'd0;
        end
    end

    always_comb begin
        n_hash      = r_hash;
        n_pend      = r_pend;
        n_gpos      = r_gpos;
        n_remain    = r_remain;
        n_open      = r_open;
        n_req_valid = r_req_valid && !i_req_ready;
        n_req       = r_req;
        if (w_accept && w_zero) begin
            // empty key: avalanche of zero goes straight to the finalizer
            n_req_valid = 1'b1;
            n_req       = '{hash: 32'd0, count: 2'd0, bytes: 24'd0};
            n_hash      = 32'd0;
            n_pend      = 24'd0;
            n_gpos      = 2'd0;
            n_remain    = 32'd0;
            n_open      = 1'b0;
        end else if (w_accept && w_live) begin
            if (w_rem1 == 32'd0) begin
                n_req_valid = 1'b1;
                n_req       = '{hash: w_step_h, count: w_step_g, bytes: w_step_p};
                n_hash      = 32'd0;
                n_pend      = 24'd0;
                n_gpos      = 2'd0;
                n_remain    = 32'd0;
                n_open      = 1'b0;
            end else begin
                n_hash   = w_step_h;
                n_pend   = w_step_p;
                n_gpos   = w_step_g;
                n_remain = w_rem1;
                n_open   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash      <= '0;
            r_pend      <= '0;
            r_gpos      <= '0;
            r_remain    <= '0;
            r_open      <= 1'b0;
            r_req_valid <= 1'b0;
        end else begin
            r_hash      <= n_hash;
            r_pend      <= n_pend;
            r_gpos      <= n_gpos;
            r_remain    <= n_remain;
            r_open      <= n_open;
            r_req_valid <= n_req_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req;
    end

endmodule

`default_nettype wire

// ===== hdl/sfh_final.sv =====
// three-stage finalize pipeline: tail mix, avalanche halves, result register
`default_nettype none

module sfh_final (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_req_valid,
    input  wire sfh_pkg::t_fin_req i_req,
    output logic                   o_req_ready,
    output logic                   o_valid,
    output logic [31:0]            o_hash_value,
    input  wire logic              i_ready
);
    import sfh_pkg::*;

    logic        r_s1_valid,  n_s1_valid;
    logic [31:0] r_s1_hash,   n_s1_hash;
    logic        r_s2_valid,  n_s2_valid;
    logic [31:0] r_s2_hash,   n_s2_hash;
    logic        r_out_valid, n_out_valid;
    logic [31:0] r_out_hash,  n_out_hash;

    logic w_en1;
    logic w_en2;
    logic w_en3;

    // a stage loads when it is empty or its content moves on
    assign w_en3 = !r_out_valid || i_ready;
    assign w_en2 = !r_s2_valid || w_en3;
    assign w_en1 = !r_s1_valid || w_en2;

    assign o_req_ready  = w_en1;
    assign o_valid      = r_out_valid;
    assign o_hash_value = r_out_hash;

    always_comb begin
        n_s1_valid  = r_s1_valid;
        n_s1_hash   = r_s1_hash;
        n_s2_valid  = r_s2_valid;
        n_s2_hash   = r_s2_hash;
        n_out_valid = r_out_valid;
        n_out_hash  = r_out_hash;
        if (w_en1) begin
            n_s1_valid = i_req_valid;
            n_s1_hash  = f_tail_mix(i_req.hash, i_req.count, i_req.bytes);
        end
        if (w_en2) begin
            n_s2_valid = r_s1_valid;
            n_s2_hash  = f_aval_a(r_s1_hash);
        end
        if (w_en3) begin
            n_out_valid = r_s2_valid;
            n_out_hash  = f_aval_b(r_s2_hash);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_s2_valid  <= n_s2_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_hash  <= n_s1_hash;
        r_s2_hash  <= n_s2_hash;
        r_out_hash <= n_out_hash;
    end

endmodule

`default_nettype wire

// ===== hdl/superfast_string_hash_top.sv =====
// top level of the streaming superfast string hash
//
//  channel   valid     ready     payload
//  input     i_valid   o_ready   i_data_byte, i_start_key, i_key_length
//  result    o_valid   i_ready   o_hash_value
//
// takes one key byte per cycle while o_ready is high; the key state register and
// its four-byte round close the only loop, so with i_ready held high the sustained
// rate is one request per cycle; the request with the last byte (or the empty key)
// then passes tail mix, first avalanche half and result register to give the hash
// synchronous active-low reset clears the open key and all valid flags
// o_ready drops only while the request register and all finalize stages are full
// and i_ready is low; requests that close no key still wait for it
`default_nettype none

module superfast_string_hash_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_start_key,
    input  wire logic [31:0] i_key_length,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_hash_value
);
    import sfh_pkg::*;

    logic     w_req_valid;
    logic     w_req_ready;
    t_fin_req w_req;

    sfh_accum u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data_byte  (i_data_byte),
        .i_start_key  (i_start_key),
        .i_key_length (i_key_length),
        .o_req_valid  (w_req_valid),
        .o_req        (w_req),
        .i_req_ready  (w_req_ready)
    );

    sfh_final u_final (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (w_req_valid),
        .i_req        (w_req),
        .o_req_ready  (w_req_ready),
        .o_valid      (o_valid),
        .o_hash_value (o_hash_value),
        .i_ready      (i_ready)
    );

endmodule

`default_nettype wire

// ===== hdl/sfh_checker.sv =====
// port-level checks for the superfast string hash, bound to the top level
`default_nettype none

`include "assert_macros.svh"

module sfh_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_ready,
    input wire logic        i_start_key,
    input wire logic [31:0] i_key_length,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [31:0] o_hash_value
);

    logic w_acc_empty;
    logic w_acc_one;

    assign w_acc_empty = i_valid && o_ready && i_start_key && (i_key_length == 32'd0);
    assign w_acc_one   = i_valid && o_ready && i_start_key && (i_key_length == 32'd1);

    // a waiting result holds its value
    `SFH_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_hash_value), "result changed while stalled")

    // with a free result side the input side never stalls
    `SFH_ASSERT_SAME(a_ready_free, i_clk, i_rst_n, !o_valid || i_ready, o_ready, "input stalled with free output")

    // an empty key hashes to zero when i_ready stays high behind it
    `SFH_ASSERT_NEXT(a_empty_key, i_clk, i_rst_n, w_acc_empty ##1 i_ready ##1 i_ready ##1 i_ready, o_valid && (o_hash_value == 32'd0), "empty key result missing or nonzero")

    // a one-byte key completes on its own request
    `SFH_ASSERT_NEXT(a_one_byte, i_clk, i_rst_n, w_acc_one ##1 i_ready ##1 i_ready ##1 i_ready, o_valid, "one-byte key result missing")

endmodule

bind superfast_string_hash_top sfh_checker u_chk (.*);

`default_nettype wire
